// ----- design/trms_pkg.sv -----
// Shared types, constants and a helper function for the throttle relay motor sequencer.
// No dependencies; imported by trms_step, throttle_relay_motor_sequencer_top and the testbench.
`default_nettype none

package trms_pkg;

  // Threshold registers and the default sample width
  localparam int unsigned LEVEL_W         = 12;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned NUM_LEVELS      = 5;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned RELAY_W         = 5;
  localparam int unsigned LAMP_W          = 2;
  localparam int unsigned MODE_CODE_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FIVE  = 3'd4;

  // Threshold reset values
  localparam logic [LEVEL_W-1:0] LEVEL_ONE_RST   = 12'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO_RST   = 12'd1700;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE_RST = 12'd2400;
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR_RST  = 12'd3100;
  localparam logic [LEVEL_W-1:0] LEVEL_FIVE_RST  = 12'd3800;

  // Lamp bits: bit 0 front, bit 1 rear
  localparam logic [LAMP_W-1:0] LAMP_NONE  = 2'b00;
  localparam logic [LAMP_W-1:0] LAMP_FRONT = 2'b01;
  localparam logic [LAMP_W-1:0] LAMP_REAR  = 2'b10;
  localparam logic [LAMP_W-1:0] LAMP_BOTH  = 2'b11;

  localparam logic [RELAY_W-1:0] RELAY_NEUTRAL = 5'b00000;

  // External mode codes
  localparam logic [MODE_CODE_W-1:0] CODE_OFF      = 3'd0;
  localparam logic [MODE_CODE_W-1:0] CODE_STARTING = 3'd1;
  localparam logic [MODE_CODE_W-1:0] CODE_BLINK    = 3'd2;
  localparam logic [MODE_CODE_W-1:0] CODE_START    = 3'd3;
  localparam logic [MODE_CODE_W-1:0] CODE_FORWARD  = 3'd4;
  localparam logic [MODE_CODE_W-1:0] CODE_REVERSE  = 3'd5;

  typedef enum logic [5:0] {
    MODE_OFF      = 6'b000001,
    MODE_STARTING = 6'b000010,
    MODE_BLINK    = 6'b000100,
    MODE_START    = 6'b001000,
    MODE_FORWARD  = 6'b010000,
    MODE_REVERSE  = 6'b100000
  } mode_e;

  typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0] levels_t;

  typedef struct packed {
    mode_e              mode;
    logic [RELAY_W-1:0] relay;
    logic [LAMP_W-1:0]  lamps;
  } seq_state_t;

  // Relay patterns per speed step (step one at index 0)
  localparam logic [NUM_LEVELS-1:0][RELAY_W-1:0] FWD_PATTERNS = {
    5'h1F, 5'h13, 5'h03, 5'h0D, 5'h05
  };
  localparam logic [NUM_LEVELS-1:0][RELAY_W-1:0] REV_PATTERNS = {
    5'h1E, 5'h12, 5'h02, 5'h0C, 5'h04
  };

  function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_e m);
    logic [MODE_CODE_W-1:0] code;
    case (m)
      MODE_OFF:      code = CODE_OFF;
      MODE_STARTING: code = CODE_STARTING;
      MODE_BLINK:    code = CODE_BLINK;
      MODE_START:    code = CODE_START;
      MODE_FORWARD:  code = CODE_FORWARD;
      MODE_REVERSE:  code = CODE_REVERSE;
      default:       code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- design/trms_step.sv -----
// Next-state logic of the sequencer: mode transitions and speed-step pattern choice.
// Depends on trms_pkg.
`default_nettype none

module trms_step #(
  parameter int unsigned SAMPLE_BITS = trms_pkg::SAMPLE_BITS_DEF
) (
  input  trms_pkg::seq_state_t   state_i,
  input  trms_pkg::levels_t      levels_i,
  input  logic [SAMPLE_BITS-1:0] throttle_i,
  input  logic                   reverse_i,
  output trms_pkg::seq_state_t   state_o
);
  import trms_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  logic [CMP_W-1:0]      thr_ext;
  logic [NUM_LEVELS-1:0] above;
  logic [RELAY_W-1:0]    pattern;
  logic                  below_one;

  assign thr_ext = CMP_W'(throttle_i);

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      above[i] = thr_ext > CMP_W'(levels_i[i]);
    end
  end

  assign below_one = thr_ext < CMP_W'(levels_i[0]);

  // The highest step exceeded wins, even if the thresholds are out of order.
  always_comb begin
    pattern = RELAY_NEUTRAL;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (above[i]) begin
        pattern = (state_i.mode == MODE_REVERSE) ? REV_PATTERNS[i] : FWD_PATTERNS[i];
      end
    end
  end

  always_comb begin
    state_o = state_i;
    case (state_i.mode)
      MODE_STARTING: begin
        state_o.mode  = below_one ? MODE_START : MODE_BLINK;
        state_o.lamps = LAMP_NONE;
      end
      MODE_START: begin
        state_o.mode  = reverse_i ? MODE_REVERSE : MODE_FORWARD;
        state_o.lamps = reverse_i ? LAMP_REAR : LAMP_FRONT;
        state_o.relay = RELAY_NEUTRAL;
      end
      MODE_FORWARD, MODE_REVERSE: begin
        if (reverse_i != (state_i.mode == MODE_REVERSE)) begin
          // Direction flipped: back to starting, no speed on this tick.
          state_o.mode  = MODE_STARTING;
          state_o.lamps = LAMP_BOTH;
          state_o.relay = RELAY_NEUTRAL;
        end else begin
          state_o.relay = pattern;
        end
      end
      default: begin
        // Off, blink and any illegal code all go to starting.
        state_o.mode  = MODE_STARTING;
        state_o.lamps = LAMP_BOTH;
        state_o.relay = RELAY_NEUTRAL;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/throttle_relay_motor_sequencer_top.sv -----
// Throttle relay motor sequencer: the result is registered and shown in the cycle after its input transfer.
// Throughput one item per cycle; the only limit is the single result register,
// which must be free or taken in the same cycle before a new transfer is accepted.
// Reset (asynchronous, active low) puts the sequencer in off with relays neutral,
// lamps dark, no result pending, and the five thresholds at their defaults.
// Depends on trms_pkg and trms_step.
`default_nettype none

module throttle_relay_motor_sequencer_top #(
  parameter int unsigned SAMPLE_BITS = trms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [trms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [trms_pkg::LEVEL_W-1:0]         cfg_data_i,

  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [SAMPLE_BITS-1:0]               throttle_sample_i,
  input  logic                                 reverse_switch_i,

  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [trms_pkg::RELAY_W-1:0]         relay_bits_o,
  output logic                                 front_led_o,
  output logic                                 reverse_led_o,
  output logic [trms_pkg::MODE_CODE_W-1:0]     mode_code_o
);
  import trms_pkg::*;

  // The sequencer state itself serves as the result register. Each result shows
  // the state just after its tick, so the state may only move on once the
  // previous result has been transferred out (or is being transferred now).
  levels_t    levels_q;
  seq_state_t state_q;
  seq_state_t state_d;
  logic       out_valid_q;
  logic       in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  trms_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .state_i    (state_q),
    .levels_i   (levels_q),
    .throttle_i (throttle_sample_i),
    .reverse_i  (reverse_switch_i),
    .state_o    (state_d)
  );

  // Threshold registers. Writes to indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q[0] <= LEVEL_ONE_RST;
      levels_q[1] <= LEVEL_TWO_RST;
      levels_q[2] <= LEVEL_THREE_RST;
      levels_q[3] <= LEVEL_FOUR_RST;
      levels_q[4] <= LEVEL_FIVE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEVEL_ONE:   levels_q[0] <= cfg_data_i;
        CFG_LEVEL_TWO:   levels_q[1] <= cfg_data_i;
        CFG_LEVEL_THREE: levels_q[2] <= cfg_data_i;
        CFG_LEVEL_FOUR:  levels_q[3] <= cfg_data_i;
        CFG_LEVEL_FIVE:  levels_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= MODE_OFF;
      state_q.relay <= RELAY_NEUTRAL;
      state_q.lamps <= LAMP_NONE;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // One result per accepted transfer; it stays valid until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign relay_bits_o  = state_q.relay;
  assign front_led_o   = state_q.lamps[0];
  assign reverse_led_o = state_q.lamps[1];
  assign mode_code_o   = mode_code(state_q.mode);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for throttle_relay_motor_sequencer_top: it offers throttle and switch
// samples under random idling and checks every result against its own model of the sequencer.
// Depends on trms_pkg and the design sources; it reads and writes no files.
module testbench;
  import trms_pkg::*;

  localparam int THR_MAX = (1 << LEVEL_W) - 1;

  // One result as the block presents it on its output ports.
  typedef struct packed {
    logic [RELAY_W-1:0]     relay;
    logic                   front;
    logic                   rear;
    logic [MODE_CODE_W-1:0] mode;
  } motor_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LEVEL_W-1:0]     cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [LEVEL_W-1:0]     throttle;
  logic                   reverse;
  logic                   out_valid;
  logic                   out_ready;
  logic [RELAY_W-1:0]     relay_bits;
  logic                   front_led;
  logic                   reverse_led;
  logic [MODE_CODE_W-1:0] mode_code;

  // Our own copy of the sequencer state and of the five threshold registers.
  logic [MODE_CODE_W-1:0] seq_mode;
  logic [RELAY_W-1:0]     seq_relay;
  logic [LAMP_W-1:0]      seq_lamps;
  logic [LEVEL_W-1:0]     level_set [NUM_LEVELS];

  // Results predicted for accepted samples, oldest first.
  motor_result_t expected_results [$];
  int unsigned   mismatch_count = 0;

  // Idling controls: the largest gap each side may draw per transfer, and a one-off long
  // hold-off that the receiving process picks up the next time it draws its stall.
  int unsigned source_gap_max = 0;
  int unsigned sink_gap_max   = 0;
  int unsigned hold_request   = 0;

  always #5 clk = ~clk;

  throttle_relay_motor_sequencer_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .throttle_sample_i (throttle),
    .reverse_switch_i  (reverse),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .relay_bits_o      (relay_bits),
    .front_led_o       (front_led),
    .reverse_led_o     (reverse_led),
    .mode_code_o       (mode_code)
  );

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Back to starting: relays neutral and both lamps lit.
  task automatic return_to_starting();
    seq_mode  = CODE_STARTING;
    seq_lamps = LAMP_BOTH;
    seq_relay = RELAY_NEUTRAL;
  endtask

  // The highest step whose threshold the throttle exceeds wins. Scanning upwards and letting
  // later steps overwrite gives the same answer even when the thresholds are out of order.
  function automatic logic [RELAY_W-1:0] speed_pattern(input logic [LEVEL_W-1:0] thr,
                                                       input logic rev);
    logic [RELAY_W-1:0] pat;
    int k;
    pat = RELAY_NEUTRAL;
    for (k = 0; k < NUM_LEVELS; k++) begin
      if (thr > level_set[k]) begin
        pat = rev ? REV_PATTERNS[k] : FWD_PATTERNS[k];
      end
    end
    return pat;
  endfunction

  // Advance our sequencer by one control tick and queue the result the block should show.
  task automatic advance_sequencer(input logic [LEVEL_W-1:0] thr, input logic rev);
    motor_result_t res;
    case (seq_mode)
      CODE_STARTING: begin
        seq_mode  = (thr < level_set[0]) ? CODE_START : CODE_BLINK;
        seq_lamps = LAMP_NONE;
      end
      CODE_BLINK: return_to_starting();
      CODE_START: begin
        if (rev) begin
          seq_mode  = CODE_REVERSE;
          seq_lamps = LAMP_REAR;
        end else begin
          seq_mode  = CODE_FORWARD;
          seq_lamps = LAMP_FRONT;
        end
        seq_relay = RELAY_NEUTRAL;
      end
      // A flipped switch drops back to starting; the speed is not reapplied on that tick.
      CODE_FORWARD: begin
        if (rev) return_to_starting();
        else seq_relay = speed_pattern(thr, 1'b0);
      end
      CODE_REVERSE: begin
        if (!rev) return_to_starting();
        else seq_relay = speed_pattern(thr, 1'b1);
      end
      default: return_to_starting();
    endcase
    res.relay = seq_relay;
    res.front = seq_lamps[0];
    res.rear  = seq_lamps[1];
    res.mode  = seq_mode;
    expected_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driving the block
  // ---------------------------------------------------------------------------------------

  // Offer one sample and return just after the rising edge at which it is transferred. Valid
  // only drops when a gap is drawn, so back-to-back samples keep it high throughout.
  task automatic offer_sample(input logic [LEVEL_W-1:0] thr, input logic rev);
    int unsigned gap;
    gap = $urandom_range(0, source_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    throttle <= thr;
    reverse  <= rev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_sequencer(thr, rev);
  endtask

  // Withdraw the input and wait until every predicted result has been transferred. The block
  // answers each sample with exactly one result, so a short pause then suffices.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    level_set[idx] = value;
  endtask

  task automatic set_levels(input logic [LEVEL_W-1:0] l1, input logic [LEVEL_W-1:0] l2,
                            input logic [LEVEL_W-1:0] l3, input logic [LEVEL_W-1:0] l4,
                            input logic [LEVEL_W-1:0] l5);
    write_level(CFG_LEVEL_ONE, l1);
    write_level(CFG_LEVEL_TWO, l2);
    write_level(CFG_LEVEL_THREE, l3);
    write_level(CFG_LEVEL_FOUR, l4);
    write_level(CFG_LEVEL_FIVE, l5);
  endtask

  // Random drive that mostly follows a well-formed run: once starting, the throttle is
  // usually below the arming level so the sequencer gets through to forward or reverse, and
  // while driving the switch is usually held, with an occasional flip back to starting. A
  // share of throttle values sit on or next to a threshold to catch off-by-one compares.
  task automatic drive_random(input int unsigned count);
    logic [LEVEL_W-1:0] thr;
    logic               rev;
    int                 lv;
    repeat (count) begin
      case (seq_mode)
        CODE_FORWARD: rev = ($urandom_range(0, 19) == 0);
        CODE_REVERSE: rev = ($urandom_range(0, 19) != 0);
        default:      rev = $urandom_range(0, 1);
      endcase
      if (seq_mode == CODE_STARTING && level_set[0] != 0 && $urandom_range(0, 4) != 0) begin
        thr = $urandom_range(0, int'(level_set[0]) - 1);
      end else if ($urandom_range(0, 9) < 3) begin
        lv = int'(level_set[$urandom_range(0, NUM_LEVELS - 1)]) + int'($urandom_range(0, 2)) - 1;
        if (lv < 0) lv = 0;
        if (lv > THR_MAX) lv = THR_MAX;
        thr = lv[LEVEL_W-1:0];
      end else begin
        thr = $urandom_range(0, THR_MAX);
      end
      offer_sample(thr, rev);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Walk the power-up sequence with the reset thresholds, including a blink cycle, then step
  // through every speed in reverse and forward just above each threshold (in reverse also on the
  // first, second and fifth threshold), with a switch flip out of each direction.
  task automatic test_power_up_and_steps();
    source_gap_max = 0;
    sink_gap_max   = 9;
    offer_sample(0, 1'b0);                       // off to starting
    offer_sample(LEVEL_ONE_RST, 1'b0);           // not below arming level: blink
    offer_sample(THR_MAX, 1'b1);                 // blink back to starting
    offer_sample(LEVEL_ONE_RST - 1, 1'b0);       // armed: start
    offer_sample(2000, 1'b1);                    // switch set: reverse, relays neutral
    offer_sample(LEVEL_ONE_RST, 1'b1);           // equal to a threshold is not above it
    offer_sample(LEVEL_ONE_RST + 1, 1'b1);
    offer_sample(LEVEL_TWO_RST, 1'b1);
    offer_sample(LEVEL_TWO_RST + 1, 1'b1);
    offer_sample(LEVEL_THREE_RST + 1, 1'b1);
    offer_sample(LEVEL_FOUR_RST + 1, 1'b1);
    offer_sample(LEVEL_FIVE_RST, 1'b1);
    offer_sample(LEVEL_FIVE_RST + 1, 1'b1);
    offer_sample(THR_MAX, 1'b1);
    offer_sample(0, 1'b1);                       // back to neutral
    offer_sample(THR_MAX, 1'b0);                 // flip out of reverse at full throttle
    offer_sample(0, 1'b0);                       // starting to start
    offer_sample(0, 1'b0);                       // start to forward
    offer_sample(LEVEL_ONE_RST + 1, 1'b0);
    offer_sample(LEVEL_TWO_RST + 1, 1'b0);
    offer_sample(LEVEL_THREE_RST + 1, 1'b0);
    offer_sample(LEVEL_FOUR_RST + 1, 1'b0);
    offer_sample(LEVEL_FIVE_RST + 1, 1'b0);
    offer_sample(THR_MAX, 1'b0);
    offer_sample(3000, 1'b1);                    // flip out of forward
  endtask

  // Thresholds at their extremes and out of order. With every level at the top the block
  // arms on almost any throttle but can never leave neutral; with every level at zero it can
  // never arm from starting, yet any non-zero throttle while driving selects the top step.
  task automatic test_threshold_extremes();
    settle_block();
    source_gap_max = 9;
    sink_gap_max   = 0;
    set_levels(THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX);
    drive_random(30);
    settle_block();
    set_levels(0, 0, 0, 0, 0);
    drive_random(30);
    settle_block();
    set_levels(3500, 600, 4000, 100, 2000);
    drive_random(60);
  endtask

  // Random thresholds, mostly ascending, with the phases cycling through four idling mixes.
  task automatic test_random_drive();
    logic [LEVEL_W-1:0] lv [NUM_LEVELS];
    int                 acc;
    int                 k;
    int                 phase;
    bit                 ordered;
    for (phase = 0; phase < 10; phase++) begin
      settle_block();
      ordered = ($urandom_range(0, 3) != 0);
      acc = 0;
      for (k = 0; k < NUM_LEVELS; k++) begin
        if (ordered) begin
          acc += $urandom_range(1, 800);
          lv[k] = acc[LEVEL_W-1:0];
        end else begin
          lv[k] = $urandom_range(0, THR_MAX);
        end
      end
      set_levels(lv[0], lv[1], lv[2], lv[3], lv[4]);
      source_gap_max = (phase % 2 == 0) ? 9 : 0;
      sink_gap_max   = (phase % 4 < 2) ? 9 : 0;
      drive_random(75);
    end
  endtask

  // The receiver stops taking results for a long stretch while samples keep coming, so the
  // result register fills and the input must stall until the hold-off ends.
  task automatic test_output_backpressure();
    settle_block();
    set_levels(LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST, LEVEL_FOUR_RST, LEVEL_FIVE_RST);
    source_gap_max = 0;
    sink_gap_max   = 0;
    hold_request   = 60;
    drive_random(80);
  endtask

  // Short bursts, each followed by a pause until every result of the burst has come back.
  task automatic test_sender_pause();
    int burst;
    source_gap_max = 3;
    sink_gap_max   = 9;
    for (burst = 0; burst < 4; burst++) begin
      drive_random(20);
      settle_block();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking: draws a stall for each transfer, then compares field by field.
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned   stall;
    motor_result_t want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        report_mismatch("result with no sample outstanding", 0, mode_code);
      end else begin
        want = expected_results.pop_front();
        if (relay_bits !== want.relay) report_mismatch("relay_bits", want.relay, relay_bits);
        if (front_led !== want.front) report_mismatch("front_led", want.front, front_led);
        if (reverse_led !== want.rear) report_mismatch("reverse_led", want.rear, reverse_led);
        if (mode_code !== want.mode) report_mismatch("mode_code", want.mode, mode_code);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LEVEL_ONE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    throttle  = '0;
    reverse   = 1'b0;
    seq_mode  = CODE_OFF;
    seq_relay = RELAY_NEUTRAL;
    seq_lamps = LAMP_NONE;
    level_set[0] = LEVEL_ONE_RST;
    level_set[1] = LEVEL_TWO_RST;
    level_set[2] = LEVEL_THREE_RST;
    level_set[3] = LEVEL_FOUR_RST;
    level_set[4] = LEVEL_FIVE_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_up_and_steps();
    test_threshold_extremes();
    test_random_drive();
    test_output_backpressure();
    test_sender_pause();

    // Drain what is still in flight, bounded so that a lost result cannot hang the run.
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", expected_results.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/trms_pkg.sv
design/trms_step.sv
design/throttle_relay_motor_sequencer_top.sv
tb/testbench.sv
